[rtl/core/bpsd_pkg.sv]
package bpsd_pkg;
	localparam int ADDR_BITS_DEF = 20;
	localparam int LEN_W = 21;
	localparam int CUR_W = 32;
	localparam int ACC_W = 40;
	localparam int DATA_W = 8;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_PATCH   = 2'd1,
		CMD_READ    = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_TOVF    = 3'd1,
		ST_SRANGE  = 3'd2,
		ST_UNWR    = 3'd3,
		ST_VARLONG = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ACT_SREAD  = 2'd0,
		ACT_LIT    = 2'd1,
		ACT_SCOPY  = 2'd2,
		ACT_TCOPY  = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		PH_CMD = 2'd0,
		PH_LIT = 2'd1,
		PH_OFS = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COPY,
		S_WAIT,
		S_TREAD,
		S_OUT
	} fsm_t;

	localparam logic [0:0] REG_SRC_LEN = 1'b0;
	localparam logic [0:0] REG_TGT_LEN = 1'b1;
endpackage

[rtl/core/bpsd_if.sv]
interface bpsd_in_if;
	import bpsd_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [19:0] address;
	logic [7:0] data;
	modport source (output valid, command, address, data, input ready);
	modport sink (input valid, command, address, data, output ready);
endinterface

interface bpsd_out_if;
	logic valid;
	logic ready;
	logic [7:0] read_data;
	logic [20:0] bytes_written;
	logic [2:0] status;
	modport source (output valid, read_data, bytes_written, status, input ready);
	modport sink (input valid, read_data, bytes_written, status, output ready);
endinterface

[rtl/core/bpsd_mem.sv]
module bpsd_mem #(
	parameter int ADDR_BITS = bpsd_pkg::ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [7:0]           wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [7:0]           rdata
);
	logic [7:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/bps_delta_patch_decoder_top.sv]
// BPS delta patch command decoder.
// Input channel "in" carries one word per transfer: command (load source byte,
// patch byte, read target byte, restart), address and data. Every accepted word
// yields exactly one word on channel "out": read_data (target byte for a read,
// else zero), bytes_written (current write position) and status (sticky error).
// Source bytes live in a source memory, produced bytes in a target memory;
// both are single-port-write, registered-read RAMs of 2^ADDR_BITS bytes.
// A source load, a literal patch byte and a restart go from accept to S_OUT,
// which registers the result. A target read passes through S_TREAD for the
// registered read first. A command that completes a copy (source read, source
// copy, target copy) loops reading one byte from memory (S_COPY) and writing
// it to the target (S_WAIT) before the next byte, so overlapping target copies
// see their own output. The block holds one word at a time: in.ready is high
// only while idle and the output register is empty, so a stalled receiver
// holds the input off. Reset clears the parser, cursors, write position,
// status and the length registers; memory contents are undefined until
// written. cfg_we writes register cfg_index (0 source_length, 1 target_length);
// the user must do so only while idle, which the block does not enforce.
module bps_delta_patch_decoder_top
	import bpsd_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bpsd_in_if.sink      in,
	bpsd_out_if.source   out,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [20:0]  cfg_data
);
	// Lengths never exceed 2^21, so a larger store caps nothing.
	localparam int DEPTH_BITS = (ADDR_BITS < LEN_W) ? ADDR_BITS : LEN_W;
	localparam logic [LEN_W:0] DEPTH = (LEN_W+1)'(1) << DEPTH_BITS;
	localparam logic [ACC_W-1:0] LAST_WEIGHT = ACC_W'(1) << 28;

	logic [LEN_W-1:0] src_len_q, tgt_len_q;
	phase_t           phase_q;
	logic [ACC_W-1:0] acc_q, wgt_q;
	act_t             act_q;
	logic [LEN_W-1:0] rem_q, wpos_q;
	logic [CUR_W-1:0] scur_q, tcur_q;
	status_t          err_q;
	fsm_t             st_q, st_d;
	logic             ovalid_q;
	logic [7:0]       ordata_q;
	logic [1:0]       cmd_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] in_addr;

	assign in_addr = ADDR_BITS'(in.address);

	// Effective store limits.
	logic [LEN_W:0] slim, tlim;
	assign slim = ({1'b0, src_len_q} < DEPTH) ? {1'b0, src_len_q} : DEPTH;
	assign tlim = ({1'b0, tgt_len_q} < DEPTH) ? {1'b0, tgt_len_q} : DEPTH;

	// Memory ports.
	logic                 s_we, t_we;
	logic [ADDR_BITS-1:0] s_waddr, s_raddr, t_waddr, t_raddr;
	logic [7:0]           s_wdata, t_wdata, s_rdata, t_rdata;

	bpsd_mem #(.ADDR_BITS(ADDR_BITS)) u_src (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	bpsd_mem #(.ADDR_BITS(ADDR_BITS)) u_tgt (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	logic acc_in;
	assign in.ready = (st_q == S_IDLE) && !ovalid_q;
	assign acc_in   = in.valid && in.ready;

	// Varint digit for the incoming byte. The weight is always a power of 128,
	// so the digit is placed by a shift.
	logic [ACC_W-1:0] digit, acc_sum, v, len_full;
	logic [LEN_W-1:0] len_sat;
	logic [CUR_W-1:0] mag;
	always_comb begin
		digit = '0;
		for (int k = 0; k < 5; k++) begin
			if (wgt_q[7*k]) digit = digit | (ACC_W'(in.data[6:0]) << (7*k));
		end
	end
	assign acc_sum  = acc_q + digit;
	assign v        = acc_sum;
	assign len_full = (v >> 2) + ACC_W'(1);
	assign len_sat  = (len_full > ACC_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : len_full[LEN_W-1:0];
	assign mag      = v[CUR_W:1];

	// A stop byte that finishes a source read command or a copy offset starts the copy loop.
	logic copy_go;
	assign copy_go = acc_in && (in.command == CMD_PATCH) && (err_q == ST_OK)
		&& (phase_q != PH_LIT) && in.data[7]
		&& ((phase_q == PH_OFS) || (phase_q == PH_CMD && act_t'(v[1:0]) == ACT_SREAD));

	// Copy step checks.
	logic        cp_err;
	status_t     cp_code;
	logic [CUR_W-1:0] cp_raddr;
	always_comb begin
		cp_err   = 1'b0;
		cp_code  = ST_OK;
		cp_raddr = '0;
		if ({1'b0, wpos_q} >= tlim) begin
			cp_err  = 1'b1;
			cp_code = ST_TOVF;
		end else begin
			unique case (act_q)
				ACT_SREAD: begin
					cp_raddr = CUR_W'(wpos_q);
					if ({1'b0, wpos_q} >= slim) begin
						cp_err = 1'b1; cp_code = ST_SRANGE;
					end
				end
				ACT_SCOPY: begin
					cp_raddr = scur_q;
					if (scur_q >= CUR_W'(slim)) begin
						cp_err = 1'b1; cp_code = ST_SRANGE;
					end
				end
				default: begin
					cp_raddr = tcur_q;
					if (tcur_q >= CUR_W'(wpos_q)) begin
						cp_err = 1'b1; cp_code = ST_UNWR;
					end
				end
			endcase
		end
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (acc_in) begin
				if (copy_go) st_d = S_COPY;
				else if (in.command == CMD_READ) st_d = S_TREAD;
				else st_d = S_OUT;
			end
			S_COPY: begin
				if (rem_q == '0 || cp_err) st_d = S_OUT;
				else st_d = S_WAIT;
			end
			S_WAIT:  st_d = S_COPY;
			S_TREAD: st_d = S_OUT;
			S_OUT:   st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		s_we    = acc_in && (in.command == CMD_LOAD);
		s_waddr = in_addr;
		s_wdata = in.data;
		s_raddr = cp_raddr[ADDR_BITS-1:0];
		t_we    = 1'b0;
		t_waddr = ADDR_BITS'(wpos_q);
		t_wdata = in.data;
		if (st_q == S_IDLE) t_raddr = in_addr;
		else if (st_q == S_TREAD) t_raddr = addr_q;
		else t_raddr = cp_raddr[ADDR_BITS-1:0];
		if (acc_in && in.command == CMD_PATCH && err_q == ST_OK && phase_q == PH_LIT
			&& {1'b0, wpos_q} < tlim) begin
			t_we = 1'b1;
		end
		if (st_q == S_WAIT) begin
			t_we    = 1'b1;
			t_wdata = (act_q == ACT_TCOPY) ? t_rdata : s_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_len_q <= '0;
			tgt_len_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_SRC_LEN) src_len_q <= cfg_data;
			else tgt_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			phase_q  <= PH_CMD;
			acc_q    <= '0;
			wgt_q    <= ACC_W'(1);
			act_q    <= ACT_SREAD;
			rem_q    <= '0;
			wpos_q   <= '0;
			scur_q   <= '0;
			tcur_q   <= '0;
			err_q    <= ST_OK;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out.valid && out.ready) ovalid_q <= 1'b0;
			if (st_q == S_OUT) ovalid_q <= 1'b1;
			if (acc_in) begin
				case (in.command)
					CMD_RESTART: begin
						phase_q <= PH_CMD;
						acc_q   <= '0;
						wgt_q   <= ACC_W'(1);
						act_q   <= ACT_SREAD;
						rem_q   <= '0;
						wpos_q  <= '0;
						scur_q  <= '0;
						tcur_q  <= '0;
						err_q   <= ST_OK;
					end
					CMD_PATCH: if (err_q == ST_OK) begin
						if (phase_q == PH_LIT) begin
							if ({1'b0, wpos_q} >= tlim) begin
								err_q <= ST_TOVF;
							end else begin
								wpos_q <= wpos_q + LEN_W'(1);
								if (rem_q <= LEN_W'(1)) phase_q <= PH_CMD;
								if (rem_q != '0) rem_q <= rem_q - LEN_W'(1);
							end
						end else if (!in.data[7]) begin
							if (wgt_q >= LAST_WEIGHT) begin
								err_q <= ST_VARLONG;
							end else begin
								wgt_q <= wgt_q << 7;
								acc_q <= acc_sum + (wgt_q << 7);
							end
						end else begin
							acc_q <= '0;
							wgt_q <= ACC_W'(1);
							if (phase_q == PH_CMD) begin
								rem_q <= len_sat;
								act_q <= act_t'(v[1:0]);
								unique case (act_t'(v[1:0]))
									ACT_SREAD: phase_q <= PH_CMD;
									ACT_LIT:   phase_q <= PH_LIT;
									default:   phase_q <= PH_OFS;
								endcase
							end else begin
								phase_q <= PH_CMD;
								if (act_q == ACT_SCOPY)
									scur_q <= v[0] ? scur_q - mag : scur_q + mag;
								else
									tcur_q <= v[0] ? tcur_q - mag : tcur_q + mag;
							end
						end
					end
					default: ;
				endcase
			end
			if (st_q == S_COPY) begin
				if (rem_q == '0) begin
					// done
				end else if (cp_err) begin
					err_q <= cp_code;
					rem_q <= '0;
				end else begin
					rem_q <= rem_q - LEN_W'(1);
					if (act_q == ACT_SCOPY) scur_q <= scur_q + CUR_W'(1);
					if (act_q == ACT_TCOPY) tcur_q <= tcur_q + CUR_W'(1);
				end
			end
			if (st_q == S_WAIT) wpos_q <= wpos_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			cmd_q  <= in.command;
			addr_q <= in_addr;
		end
		if (st_q == S_OUT) begin
			ordata_q <= (cmd_q == CMD_READ) ? t_rdata : 8'd0;
		end
	end

	assign out.valid         = ovalid_q;
	assign out.read_data     = ordata_q;
	assign out.bytes_written = wpos_q;
	assign out.status        = err_q;
endmodule

[rtl/core/bpsd_checker.sv]
module bpsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_no_out_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= 3'd4)) else $error("bad status");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind bps_delta_patch_decoder_top bpsd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .status(out.status)
);
